// ===== rtl/mik_pkg.sv =====
package mik_pkg;

   // Fraction bits of the command, geometry and scale formats.
   localparam int FRAC_BITS = 8;

   // Field widths of one command and one result.
   localparam int VEL_W       = 16;
   localparam int SPEED_W     = 16;
   localparam int NUM_WHEELS  = 4;
   localparam int WHEEL_W     = SPEED_W + 1;
   localparam int REQ_DATA_W  = 3 * VEL_W;
   localparam int RSP_FIELD_W = NUM_WHEELS * WHEEL_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   // Register widths.
   localparam int GEOM_W  = 16;
   localparam int COEF_W  = 24;
   localparam int THRESH_W = 16;
   localparam int GAIN_W  = 12;
   localparam int MINSPD_W = 16;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   // Internal arithmetic widths.
   localparam int SUMV_W   = VEL_W + 1;
   localparam int GW_W     = GEOM_W + VEL_W + 1;
   localparam int TERM_W   = ((SUMV_W + FRAC_BITS > GW_W) ? SUMV_W + FRAC_BITS : GW_W) + 1;
   localparam int MAG_W    = TERM_W;
   localparam int PROD1_W  = MAG_W + COEF_W;
   localparam int PROD2_W  = PROD1_W + GAIN_W;
   localparam int WRAP_W   = 64;
   localparam int SHIFT1   = 3 * FRAC_BITS;
   localparam int SHIFT2   = 4 * FRAC_BITS;

   // Register reset values.
   localparam logic [GEOM_W-1:0]   GEOM_RESET   = GEOM_W'(256);
   localparam logic [COEF_W-1:0]   COEF_RESET   = COEF_W'(256);
   localparam logic [THRESH_W-1:0] STOP_RESET   = THRESH_W'(1);
   localparam logic [THRESH_W-1:0] LOWLIM_RESET = THRESH_W'(0);
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(256);
   localparam logic [MINSPD_W-1:0] MINSPD_RESET = MINSPD_W'(0);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GEOMETRY_FACTOR     = 3'd0,
      CSR_SPEED_COEFFICIENT   = 3'd1,
      CSR_STOP_THRESHOLD      = 3'd2,
      CSR_LOW_SPEED_LIMIT     = 3'd3,
      CSR_LOW_SPEED_GAIN      = 3'd4,
      CSR_MINIMUM_MOTOR_SPEED = 3'd5
   } csr_idx_type;

endpackage

// ===== rtl/mecanum_inverse_kinematics.sv =====
// Four-wheel mecanum inverse kinematics. Each command transfer on req_ carries
// forward velocity, lateral velocity and yaw rate (signed Q7.8) and yields one
// result transfer on rsp_ with a saturated integer speed and a direction bit for
// the front left, front right, rear left and rear right wheels. The datapath is
// a five-stage pipeline (input compare and geometry multiply, wheel sums and
// magnitudes, coefficient multiply, gain multiply, saturation and output
// register); one command is taken every cycle unless back-pressure freezes it.
// Back-pressure on rsp_tready freezes the whole pipeline, so req_tready follows
// the output register. The user must write registers through csr_ only while no
// command is in flight; the block does not enforce it. Writes apply to the next command.
module mecanum_inverse_kinematics (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: forward_velocity[15:0], lateral_velocity[15:0], yaw_rate[15:0].
   input  logic [mik_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: front_left_speed[15:0], front_left_dir, front_right_speed[15:0],
   // front_right_dir, rear_left_speed[15:0], rear_left_dir, rear_right_speed[15:0],
   // rear_right_dir, then zero padding.
   output logic [mik_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [mik_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [mik_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import mik_pkg::*;

   function automatic logic [VEL_W:0] abs_vel(input logic signed [VEL_W-1:0] v);
      logic signed [VEL_W:0] e;
      e = {v[VEL_W-1], v};
      return v[VEL_W-1] ? (VEL_W+1)'(-e) : (VEL_W+1)'(e);
   endfunction

   // Configuration registers.
   logic [GEOM_W-1:0]   geom_ff;
   logic [COEF_W-1:0]   coef_ff;
   logic [THRESH_W-1:0] stop_ff;
   logic [THRESH_W-1:0] lowlim_ff;
   logic [GAIN_W-1:0]   gain_ff;
   logic [MINSPD_W-1:0] minspd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff   <= GEOM_RESET;
         coef_ff   <= COEF_RESET;
         stop_ff   <= STOP_RESET;
         lowlim_ff <= LOWLIM_RESET;
         gain_ff   <= GAIN_RESET;
         minspd_ff <= MINSPD_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_GEOMETRY_FACTOR:     geom_ff   <= csr_wdata[GEOM_W-1:0];
            CSR_SPEED_COEFFICIENT:   coef_ff   <= csr_wdata[COEF_W-1:0];
            CSR_STOP_THRESHOLD:      stop_ff   <= csr_wdata[THRESH_W-1:0];
            CSR_LOW_SPEED_LIMIT:     lowlim_ff <= csr_wdata[THRESH_W-1:0];
            CSR_LOW_SPEED_GAIN:      gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_MINIMUM_MOTOR_SPEED: minspd_ff <= csr_wdata[MINSPD_W-1:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves when the output register is empty or drained.
   logic adv;
   logic rsp_v_ff;
   assign adv        = !rsp_v_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_v_ff;

   // Stage 1: stillness and low-speed compares, velocity sums, geometry product.
   logic signed [VEL_W-1:0]  vx, vy, wz;
   logic [VEL_W:0]           ax, ay, aw;
   logic                     still_in, gain_in;
   logic signed [SUMV_W-1:0] dif_in, sum_in;
   logic signed [GW_W-1:0]   gw_in;

   assign vx = req_tdata[0*VEL_W +: VEL_W];
   assign vy = req_tdata[1*VEL_W +: VEL_W];
   assign wz = req_tdata[2*VEL_W +: VEL_W];

   always_comb begin
      ax       = abs_vel(vx);
      ay       = abs_vel(vy);
      aw       = abs_vel(wz);
      still_in = (ax < {1'b0, stop_ff}) && (ay < {1'b0, stop_ff}) && (aw < {1'b0, stop_ff});
      gain_in  = (ax < {1'b0, lowlim_ff}) && (ay < {1'b0, lowlim_ff});
      dif_in   = $signed({vx[VEL_W-1], vx}) - $signed({vy[VEL_W-1], vy});
      sum_in   = $signed({vx[VEL_W-1], vx}) + $signed({vy[VEL_W-1], vy});
      gw_in    = $signed({1'b0, geom_ff}) * $signed(wz);
   end

   logic                     s1_v_ff, s1_still_ff, s1_gain_ff;
   logic signed [SUMV_W-1:0] s1_dif_ff, s1_sum_ff;
   logic signed [GW_W-1:0]   s1_gw_ff;

   // Stage 2: the four wheel terms, split into sign and magnitude.
   logic signed [TERM_W-1:0] dsc, ssc, gwx;
   logic signed [TERM_W-1:0] term_in [NUM_WHEELS];
   logic [MAG_W-1:0]         mag_in  [NUM_WHEELS];
   logic [NUM_WHEELS-1:0]    neg_in;

   always_comb begin
      dsc = TERM_W'(s1_dif_ff) <<< FRAC_BITS;
      ssc = TERM_W'(s1_sum_ff) <<< FRAC_BITS;
      gwx = TERM_W'(s1_gw_ff);
      term_in[0] = dsc - gwx;
      term_in[1] = ssc + gwx;
      term_in[2] = ssc - gwx;
      term_in[3] = dsc + gwx;
      for (int k = 0; k < NUM_WHEELS; k++) begin
         neg_in[k] = term_in[k][TERM_W-1];
         mag_in[k] = neg_in[k] ? MAG_W'(-term_in[k]) : MAG_W'(term_in[k]);
      end
   end

   logic                  s2_v_ff, s2_still_ff, s2_gain_ff;
   logic [NUM_WHEELS-1:0] s2_neg_ff;
   logic [MAG_W-1:0]      s2_mag_ff [NUM_WHEELS];

   // Stage 3: scale by the speed coefficient.
   logic                  s3_v_ff, s3_still_ff, s3_gain_ff;
   logic [NUM_WHEELS-1:0] s3_neg_ff;
   logic [PROD1_W-1:0]    s3_m_ff [NUM_WHEELS];

   // Stage 4: scale by the low-speed gain; the ungained product rides along.
   logic                  s4_v_ff, s4_still_ff, s4_gain_ff;
   logic [NUM_WHEELS-1:0] s4_neg_ff;
   logic [PROD1_W-1:0]    s4_m_ff [NUM_WHEELS];
   logic [PROD2_W-1:0]    s4_p_ff [NUM_WHEELS];

   // Stage 5: pick the integer part, saturate, raise to the minimum speed, zero a still command.
   logic [SPEED_W-1:0]    spd_in [NUM_WHEELS];
   logic [NUM_WHEELS-1:0] dir_in;
   logic                  zero_k, hi_k;

   always_comb begin
      for (int k = 0; k < NUM_WHEELS; k++) begin
         // A gained product is tested for zero after wrapping to 64 bits.
         if (s4_gain_ff) begin
            zero_k    = (s4_p_ff[k][WRAP_W-1:0] == '0);
            hi_k      = |s4_p_ff[k][PROD2_W-1:SHIFT2+SPEED_W];
            spd_in[k] = s4_p_ff[k][SHIFT2 +: SPEED_W];
         end else begin
            zero_k    = (s4_m_ff[k] == '0);
            hi_k      = |s4_m_ff[k][PROD1_W-1:SHIFT1+SPEED_W];
            spd_in[k] = s4_m_ff[k][SHIFT1 +: SPEED_W];
         end
         if (hi_k) begin
            spd_in[k] = '1;
         end
         if (!zero_k && (spd_in[k] < minspd_ff)) begin
            spd_in[k] = minspd_ff;
         end
         dir_in[k] = !s4_neg_ff[k] || zero_k;
         if (s4_still_ff) begin
            spd_in[k] = '0;
            dir_in[k] = 1'b0;
         end
      end
   end

   logic [SPEED_W-1:0]    spd_ff [NUM_WHEELS];
   logic [NUM_WHEELS-1:0] dir_ff;

   // Valid bits of every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= req_tvalid;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         s4_v_ff  <= s3_v_ff;
         rsp_v_ff <= s4_v_ff;
      end
   end

   // Payload of every stage.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_still_ff <= still_in;
         s1_gain_ff  <= gain_in;
         s1_dif_ff   <= dif_in;
         s1_sum_ff   <= sum_in;
         s1_gw_ff    <= gw_in;

         s2_still_ff <= s1_still_ff;
         s2_gain_ff  <= s1_gain_ff;
         s2_neg_ff   <= neg_in;

         s3_still_ff <= s2_still_ff;
         s3_gain_ff  <= s2_gain_ff;
         s3_neg_ff   <= s2_neg_ff;

         s4_still_ff <= s3_still_ff;
         s4_gain_ff  <= s3_gain_ff;
         s4_neg_ff   <= s3_neg_ff;

         dir_ff      <= dir_in;

         for (int k = 0; k < NUM_WHEELS; k++) begin
            s2_mag_ff[k] <= mag_in[k];
            s3_m_ff[k]   <= PROD1_W'(s2_mag_ff[k]) * PROD1_W'(coef_ff);
            s4_m_ff[k]   <= s3_m_ff[k];
            s4_p_ff[k]   <= PROD2_W'(s3_m_ff[k]) * PROD2_W'(gain_ff);
            spd_ff[k]    <= spd_in[k];
         end
      end
   end

   // Result packing.
   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < NUM_WHEELS; k++) begin
         rsp_tdata[k*WHEEL_W +: SPEED_W]  = spd_ff[k];
         rsp_tdata[k*WHEEL_W + SPEED_W]   = dir_ff[k];
      end
   end

   // The output only becomes valid when the last stage held an item.
   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> $past(s4_v_ff))
      else $error("output became valid without an item in the last stage");

   // A frozen pipeline keeps its first-stage payload.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !adv |=> $stable(s1_gw_ff) && $stable(s1_dif_ff) && $stable(s1_sum_ff))
      else $error("first stage payload changed during a stall");

   // A still command leaves all speeds and directions at zero.
   a_still_zero: assert property (@(posedge clock) disable iff (reset)
      s4_v_ff && s4_still_ff && adv |=> rsp_tdata == '0)
      else $error("still command produced a nonzero result");

endmodule
